@@ rtl/hdd_pkg.sv @@
// hall direction decoder package: sector tables, direction codes, shared types
// no dependencies

package hdd_pkg;

  localparam int unsigned NUM_ROWS = 6;

  localparam logic [1:0] DIR_SAME = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;
  localparam logic [1:0] DIR_BAD  = 2'd3;

  localparam logic [2:0] LAST_ROW = 3'(NUM_ROWS - 1);

  // hall code to sector, one row per wiring option; codes 0 and 7 give 0
  localparam logic [2:0] SECTOR_TABLE [NUM_ROWS][8] = '{
    '{3'd0, 3'd1, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4, 3'd0},
    '{3'd0, 3'd2, 3'd6, 3'd1, 3'd4, 3'd3, 3'd5, 3'd0},
    '{3'd0, 3'd3, 3'd1, 3'd2, 3'd5, 3'd4, 3'd6, 3'd0},
    '{3'd0, 3'd4, 3'd2, 3'd3, 3'd6, 3'd5, 3'd1, 3'd0},
    '{3'd0, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd0},
    '{3'd0, 3'd6, 3'd4, 3'd5, 3'd2, 3'd1, 3'd3, 3'd0}
  };

  typedef struct packed {
    logic [2:0] prev_code;
    logic       prev_valid;
    logic       change_flag;
  } hdd_state_t;

  typedef struct packed {
    logic [1:0] direction;
    logic       state_changed;
    logic [2:0] hall_code;
    logic [2:0] angle_sixths;
    logic       angle_valid;
  } hdd_result_t;

  function automatic logic [2:0] sector_of(input logic [2:0] row, input logic [2:0] code);
    logic [2:0] r;
    r = (row > LAST_ROW) ? LAST_ROW : row;
    return SECTOR_TABLE[r][code];
  endfunction

endpackage

@@ rtl/hall_direction_decoder.sv @@
// hall direction decoder top: input register, decode step, result register
// a word passes the input register, then the result register; throughput one word per
// cycle while out_stall is low, set by the single decode pass between both registers
// synchronous active-low reset clears valids, kept hall state and map_row
// depends on hdd_pkg and hdd_step

module hall_direction_decoder import hdd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_hall_pins,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_direction,
  output logic       out_state_changed,
  output logic [2:0] out_hall_code,
  output logic [2:0] out_angle_sixths,
  output logic       out_angle_valid
);

  logic [2:0]  map_row_r;
  logic        s1_valid_r;
  logic [2:0]  s1_code_r;
  logic        out_valid_r;
  hdd_result_t out_r;
  hdd_state_t  state_r;
  hdd_state_t  state_nxt;
  hdd_result_t result_nxt;
  logic        out_free;
  logic        s1_move;
  logic        in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  hdd_step u_step (
    .code      (s1_code_r),
    .map_row   (map_row_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_row_r   <= 3'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        map_row_r <= cfg_wr_data;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r <= ~in_hall_pins;
    end
    if (s1_move) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_direction     = out_r.direction;
  assign out_state_changed = out_r.state_changed;
  assign out_hall_code     = out_r.hall_code;
  assign out_angle_sixths  = out_r.angle_sixths;
  assign out_angle_valid   = out_r.angle_valid;

endmodule

@@ rtl/hdd_step.sv @@
// hall direction decoder: combinational decode of one registered sample
// against the kept state; depends on hdd_pkg

module hdd_step import hdd_pkg::*; (
  input  logic [2:0]  code,
  input  logic [2:0]  map_row,
  input  hdd_state_t  state_cur,
  output hdd_state_t  state_nxt,
  output hdd_result_t result
);

  logic [2:0] cur_sector;
  logic [2:0] prev_sector;
  logic [3:0] cur_ext;
  logic [3:0] prev_ext;
  logic       code_ok;
  logic       step_pos;
  logic       step_neg;

  always_comb begin
    cur_sector  = sector_of(map_row, code);
    prev_sector = sector_of(map_row, state_cur.prev_code);
    cur_ext     = {1'b0, cur_sector};
    prev_ext    = {1'b0, prev_sector};
    code_ok     = (code != 3'd0) && (code != 3'd7);
    // one sector back (with wrap from 1 to 6) is forward rotation
    step_pos    = (prev_ext == cur_ext + 4'd1) ||
                  ((cur_sector == 3'd6) && (prev_sector == 3'd1));
    step_neg    = (cur_ext == prev_ext + 4'd1) ||
                  ((cur_sector == 3'd1) && (prev_sector == 3'd6));

    state_nxt          = state_cur;
    result.hall_code   = code;
    result.angle_valid = code_ok;
    result.angle_sixths = 3'd0;
    result.direction   = DIR_SAME;

    if (!code_ok) begin
      state_nxt.prev_valid = 1'b0;
      result.direction     = DIR_BAD;
    end else begin
      result.angle_sixths = (cur_sector == 3'd6) ? 3'd0 : 3'd6 - cur_sector;
      if (!state_cur.prev_valid) begin
        state_nxt.prev_code  = code;
        state_nxt.prev_valid = 1'b1;
      end else if (code != state_cur.prev_code) begin
        if (step_pos) begin
          result.direction = DIR_POS;
        end else if (step_neg) begin
          result.direction = DIR_NEG;
        end else begin
          result.direction = DIR_BAD;
        end
        state_nxt.prev_code   = code;
        state_nxt.change_flag = 1'b1;
      end else begin
        state_nxt.change_flag = 1'b0;
      end
    end
    result.state_changed = state_nxt.change_flag;
  end

endmodule

@@ sim/hdd_checker.sv @@
// hdd_checker: watches the hall decoder channels, predicts each result word and compares
// keeps its own wiring tables and kept hall state; depends on hdd_pkg for codes and layout

module hdd_checker import hdd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_hall_pins,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_direction,
  input  logic       out_state_changed,
  input  logic [2:0] out_hall_code,
  input  logic [2:0] out_angle_sixths,
  input  logic       out_angle_valid,
  output int         fail_count,
  output int         pending
);

  localparam logic [2:0] TOP_ROW = 3'd5;
  localparam logic [2:0] CODE_NONE = 3'd0;
  localparam logic [2:0] CODE_ALL = 3'd7;

  // hall code to sector per wiring option
  localparam logic [2:0] WIRING [6][8] = '{
    '{3'd0, 3'd1, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4, 3'd0},
    '{3'd0, 3'd2, 3'd6, 3'd1, 3'd4, 3'd3, 3'd5, 3'd0},
    '{3'd0, 3'd3, 3'd1, 3'd2, 3'd5, 3'd4, 3'd6, 3'd0},
    '{3'd0, 3'd4, 3'd2, 3'd3, 3'd6, 3'd5, 3'd1, 3'd0},
    '{3'd0, 3'd5, 3'd3, 3'd4, 3'd1, 3'd6, 3'd2, 3'd0},
    '{3'd0, 3'd6, 3'd4, 3'd5, 3'd2, 3'd1, 3'd3, 3'd0}
  };

  logic [2:0]  wiring_row;
  logic [2:0]  last_code;
  logic        seen_valid;
  logic        moved;
  hdd_result_t decoded_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic decode_sample(input logic [2:0] pins, output hdd_result_t r);
    logic [2:0] code;
    logic [2:0] row;
    logic [2:0] now_sector;
    logic [2:0] was_sector;
    int         delta;
    code = ~pins;
    // rows past the last table stick at the last one
    row = (wiring_row > TOP_ROW) ? TOP_ROW : wiring_row;
    r = '0;
    r.hall_code = code;
    if (code == CODE_NONE || code == CODE_ALL) begin
      seen_valid = 1'b0;
      r.direction = DIR_BAD;
    end else begin
      now_sector = WIRING[row][code];
      r.angle_valid = 1'b1;
      r.angle_sixths = (now_sector == 3'd6) ? 3'd0 : 3'd6 - now_sector;
      if (!seen_valid) begin
        last_code = code;
        seen_valid = 1'b1;
        r.direction = DIR_SAME;
      end else if (code != last_code) begin
        was_sector = WIRING[row][last_code];
        delta = int'(now_sector) - int'(was_sector);
        if (delta == -1 || delta == 5) begin
          r.direction = DIR_POS;
        end else if (delta == 1 || delta == -5) begin
          r.direction = DIR_NEG;
        end else begin
          r.direction = DIR_BAD;
        end
        last_code = code;
        moved = 1'b1;
      end else begin
        r.direction = DIR_SAME;
        moved = 1'b0;
      end
    end
    r.state_changed = moved;
  endtask

  always @(posedge clk) begin : watch
    hdd_result_t got;
    hdd_result_t want;
    if (!rst_n) begin
      wiring_row = '0;
      last_code = '0;
      seen_valid = 1'b0;
      moved = 1'b0;
      decoded_q.delete();
      pending = 0;
    end else begin
      if (cfg_wr_en) begin
        wiring_row = cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        got.direction = out_direction;
        got.state_changed = out_state_changed;
        got.hall_code = out_hall_code;
        got.angle_sixths = out_angle_sixths;
        got.angle_valid = out_angle_valid;
        if (decoded_q.size() == 0) begin
          report_mismatch("result word with none outstanding, hall_code", got.hall_code, 0);
        end else begin
          want = decoded_q.pop_front();
          if (got.direction !== want.direction)
            report_mismatch("direction", got.direction, want.direction);
          if (got.state_changed !== want.state_changed)
            report_mismatch("state_changed", got.state_changed, want.state_changed);
          if (got.hall_code !== want.hall_code)
            report_mismatch("hall_code", got.hall_code, want.hall_code);
          if (got.angle_sixths !== want.angle_sixths)
            report_mismatch("angle_sixths", got.angle_sixths, want.angle_sixths);
          if (got.angle_valid !== want.angle_valid)
            report_mismatch("angle_valid", got.angle_valid, want.angle_valid);
        end
      end
      if (in_valid && !in_stall) begin
        decode_sample(in_hall_pins, want);
        decoded_q.push_back(want);
      end
      pending = decoded_q.size();
    end
  end

endmodule

@@ sim/tb_hall_direction_decoder.sv @@
// tb_hall_direction_decoder: drives hall samples and map_row writes with bursty input and a
// stalling receiver; depends on hall_direction_decoder, hdd_pkg and hdd_checker

module tb_hall_direction_decoder;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD = 250;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 100;

  typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_t;

  // one full turn in hall codes; adjacent entries differ by one pin
  localparam logic [2:0] TURN_ORDER [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

  // both dead codes, first sample, same, forward and backward with wrap, skips
  localparam logic [2:0] OPENING_CODES [22] = '{
    3'd0, 3'd7, 3'd1, 3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5, 3'd1, 3'd5,
    3'd4, 3'd6, 3'd2, 3'd3, 3'd1, 3'd4, 3'd2, 3'd7, 3'd6, 3'd6, 3'd5
  };
  localparam logic [2:0] SATURATED_CODES [4] = '{3'd3, 3'd1, 3'd2, 3'd0};
  localparam logic [2:0] PHASE_ROWS [4] = '{3'd0, 3'd5, 3'd6, 3'd7};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_hall_pins;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_direction;
  logic       out_state_changed;
  logic [2:0] out_hall_code;
  logic [2:0] out_angle_sixths;
  logic       out_angle_valid;

  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b0;
  bit       hold_req = 1'b0;
  rx_mode_t rx_mode = RX_FREE;

  hall_direction_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_hall_pins      (in_hall_pins),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_direction     (out_direction),
    .out_state_changed (out_state_changed),
    .out_hall_code     (out_hall_code),
    .out_angle_sixths  (out_angle_sixths),
    .out_angle_valid   (out_angle_valid)
  );

  hdd_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_hall_pins      (in_hall_pins),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_direction     (out_direction),
    .out_state_changed (out_state_changed),
    .out_hall_code     (out_hall_code),
    .out_angle_sixths  (out_angle_sixths),
    .out_angle_valid   (out_angle_valid),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: stall segments of random length, or one long hold-off on request
  initial begin : rx_side
    int   span;
    logic level;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        level = 1'b1;
        span = LONG_HOLD;
      end else begin
        span = $urandom_range(1, 6);
        case (rx_mode)
          RX_FREE:  level = 1'b0;
          RX_LIGHT: level = ($urandom_range(0, 3) == 0);
          default:  level = ($urandom_range(0, 3) != 0);
        endcase
      end
      @(negedge clk);
      out_stall <= level;
      repeat (span - 1) @(negedge clk);
    end
  end

  task automatic offer_code(input logic [2:0] code);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_hall_pins <= ~code;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every result word is back, then lets the pipe settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_map_row(input logic [2:0] row);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= row;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly clean rotation with reversals, plus repeats, jumps and raw pin noise
  task automatic run_phase(input int count);
    int         idx;
    int         stride;
    int         pick;
    logic [2:0] code;
    idx = $urandom_range(0, 5);
    stride = $urandom_range(0, 1) ? 1 : 5;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        if ($urandom_range(0, 15) == 0) stride = 6 - stride;
        idx = (idx + stride) % 6;
        code = TURN_ORDER[idx];
      end else if (pick < 80) begin
        code = TURN_ORDER[idx];
      end else if (pick < 88) begin
        idx = $urandom_range(0, 5);
        code = TURN_ORDER[idx];
      end else begin
        code = 3'($urandom_range(0, 7));
      end
      offer_code(code);
    end
  endtask

  initial begin : stimulus
    logic [2:0] row;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_hall_pins = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (OPENING_CODES[i]) offer_code(OPENING_CODES[i]);
    drain();
    write_map_row(3'd7);
    foreach (SATURATED_CODES[i]) offer_code(SATURATED_CODES[i]);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      row = (ph < 4) ? PHASE_ROWS[ph] : 3'($urandom_range(0, 7));
      write_map_row(row);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      if (ph == 2) begin
        // back-to-back words against a long receiver hold-off
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      run_phase(PHASE_WORDS);
      drain();
    end

    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
